/* hw/rtl/lnr_pkg.sv */
// ----------------------------------------------------------------------------
// lnr_pkg
// Shared types and constants for the layer normalization row block.
// ----------------------------------------------------------------------------
`default_nettype none

package lnr_pkg;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_ELEM = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_ROW_LENGTH = 1'b0,
    CFG_EPS        = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_V_RD,
    ST_V_D,
    ST_V_SQ,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_INV_GO,
    ST_INV_WAIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_O_RD,
    ST_O_D,
    ST_O_M1,
    ST_O_M2,
    ST_O_GO,
    ST_O_WAIT,
    ST_O_OUT
  } state_t;

  // Shared divider and square root widths.
  localparam int DIV_W  = 52;
  localparam int SQ_W   = 50;
  localparam int ROOT_W = 25;

  localparam logic [DIV_W-1:0]  INV_NUM       = DIV_W'(64'h1_0000_0000_0000);
  localparam logic [ROOT_W-1:0] INV_ZERO      = 25'h100_0000;
  localparam logic [15:0]       SCALE_ONE     = 16'h1000;
  localparam logic [15:0]       SHIFT_ZERO    = 16'h0000;
  localparam logic [6:0]        ROW_LEN_RESET = 7'd64;
  localparam logic [15:0]       EPS_RESET     = 16'd1;

endpackage

`default_nettype wire

/* hw/rtl/lnr_div.sv */
// ----------------------------------------------------------------------------
// lnr_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lnr_div import lnr_pkg::*; (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire  [DIV_W-1:0] dividend,
  input  wire  [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] dvs_r;
  logic [DIV_W:0]   rem_t;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign rem_t = {rem_r, quo_r[DIV_W-1]};
  assign diff  = rem_t - {1'b0, dvs_r};
  assign ge    = rem_t >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIV_W-1:0] : rem_t[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= CW'(cnt_r + 1'b1);
        if (cnt_r == CW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* hw/rtl/lnr_isqrt.sv */
// ----------------------------------------------------------------------------
// lnr_isqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lnr_isqrt import lnr_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire  [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int RW = ROOT_W + 3;
  localparam int CW = $clog2(ROOT_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [RW-1:0]     rem_r;
  logic [SQ_W-1:0]   src_r;
  logic [ROOT_W-1:0] root_r;
  logic [RW-1:0]     rem_t;
  logic [RW-1:0]     trial;
  logic              ge;

  assign rem_t = {rem_r[RW-3:0], src_r[SQ_W-1 -: 2]};
  assign trial = {{(RW-ROOT_W-2){1'b0}}, root_r, 2'b01};
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        root_r <= '0;
        src_r  <= radicand;
      end else if (busy_r) begin
        rem_r  <= ge ? RW'(rem_t - trial) : rem_t;
        root_r <= {root_r[ROOT_W-2:0], ge};
        src_r  <= {src_r[SQ_W-3:0], 2'b00};
        cnt_r  <= CW'(cnt_r + 1'b1);
        if (cnt_r == CW'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

/* hw/rtl/layer_norm_row.sv */
// ----------------------------------------------------------------------------
// layer_norm_row
// Fixed-point layer normalization of one token row, built around row and
// parameter memories with registered reads.
// ----------------------------------------------------------------------------
// Usage: input transactions either load one scale/shift entry (cmd load) or
// carry one Q8.8 row element. Elements are taken one per cycle while the block
// is idle. The element that brings the count to the row length starts the
// normalization; in_stall stays high until the last result of that row has
// been placed in the output register.
// Sequence: the variance pass reads, differences and squares each element,
// then two 52-step divisions and a 25-step square root (only the first
// division when variance plus eps is zero) precede the first result. Each
// result uses the shared 52-step serial divider to divide by the row length.
// The output register holds a result while out_stall is high; the sequencer
// waits for it to drain, and load or element transactions of the next row are
// accepted while the final result still waits.
// Reset (synchronous, active low) restores the scale table to 1.0 and the
// shift table to zero through per-entry valid bits, clears the row count and
// sum, and sets row_length to 64 and eps to 1. No clearing pass is needed.
// Table and row memories are only written while idle, and their reads are
// used only during normalization, so no read/write forwarding is required.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_norm_row import lnr_pkg::*; #(
  parameter int EMB_DIM = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  // Input channel
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_cmd,
  input  wire         [5:0] in_index,
  input  wire  signed [15:0] in_sample,
  input  wire  signed [15:0] in_shift_value,
  // Result channel
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] out_value,
  output logic        [5:0] out_position,
  output logic              out_last,
  output logic              out_saturated,
  // Configuration write channel
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire               cfg_index,
  input  wire        [15:0] cfg_data
);

  localparam int AW = (EMB_DIM > 1) ? $clog2(EMB_DIM) : 1;
  localparam logic [6:0] DIM7 = 7'(EMB_DIM);
  localparam logic signed [37:0] YMAX = 38'sd32767;
  localparam logic signed [37:0] YMIN = -38'sd32768;

  // Memories: row buffer and packed {scale, shift} table.
  logic [15:0] row_mem [EMB_DIM];
  logic [31:0] par_mem [EMB_DIM];
  logic [EMB_DIM-1:0] pvld_r;
  logic [15:0] row_rd_r;
  logic [31:0] par_rd_r;
  logic        pv_rd_r;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [6:0]  rl_r;
  logic [15:0] eps_r;

  // Row accumulation.
  logic [6:0]         count_r;
  logic signed [21:0] sum_r;
  logic [6:0]         count_inc;
  logic [6:0]         eff_len;

  // Normalization datapath.
  logic [6:0]        n_r;
  logic [6:0]        i_r;
  logic [13:0]       n2_r;
  logic [20:0]       n3_r;
  logic [DIV_W-1:0]  ssq_r;
  logic [DIV_W-1:0]  v_r;
  logic [SQ_W-1:0]   sq_src_r;
  logic [ROOT_W-1:0] inv_r;
  logic [23:0]       dm_r;
  logic [15:0]       gm_r;
  logic              sgn_r;
  logic signed [15:0] shv_r;
  logic [48:0]       m1_r;
  logic [35:0]       t_r;
  logic [35:0]       q_r;

  logic              out_valid_r;
  logic signed [15:0] out_value_r;
  logic [5:0]        out_pos_r;
  logic              out_last_r;
  logic              out_sat_r;

  // Shared units.
  logic              div_start;
  logic [DIV_W-1:0]  div_a;
  logic [DIV_W-1:0]  div_b;
  logic              div_done;
  logic [DIV_W-1:0]  div_q;
  logic              sq_start;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;

  // Combinational helpers.
  logic               in_acc;
  logic               elem_acc;
  logic               load_acc;
  logic signed [7:0]  n_s;
  logic signed [15:0] x_s;
  logic signed [23:0] nx;
  logic signed [24:0] d_s;
  logic [23:0]        dm;
  logic [47:0]        sq;
  logic signed [15:0] g_s;
  logic [15:0]        g_raw;
  logic [15:0]        s_raw;
  logic [64:0]        p;
  logic [63:0]        tsum;
  logic signed [37:0] qs;
  logic signed [37:0] ys;
  logic signed [37:0] y;
  logic               out_free;
  logic               last_elem;
  logic [DIV_W:0]     vsum;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign elem_acc  = in_acc && (in_cmd == CMD_ELEM);
  assign load_acc  = in_acc && (in_cmd == CMD_LOAD) && ({1'b0, in_index} < DIM7);

  assign eff_len   = (rl_r == 7'd0) ? 7'd1 : ((rl_r > DIM7) ? DIM7 : rl_r);
  assign count_inc = (count_r < DIM7) ? 7'(count_r + 7'd1) : count_r;

  // Deviation n*x - sum from the registered row read.
  assign n_s = signed'({1'b0, n_r});
  assign x_s = signed'(row_rd_r);
  assign nx  = n_s * x_s;
  assign d_s = 25'(nx) - 25'(sum_r);
  assign dm  = d_s[24] ? 24'(-d_s) : 24'(d_s);
  assign sq  = dm_r * dm_r;

  // Table entries that were never loaded read as scale 1.0, shift 0.
  assign g_raw = pv_rd_r ? par_rd_r[31:16] : SCALE_ONE;
  assign s_raw = pv_rd_r ? par_rd_r[15:0]  : SHIFT_ZERO;
  assign g_s   = signed'(g_raw);

  assign p    = m1_r * gm_r;
  assign tsum = p[63:0] + 64'({n_r, 27'b0});

  assign qs = signed'({2'b00, q_r});
  assign ys = sgn_r ? -qs : qs;
  assign y  = ys + 38'(shv_r);

  assign vsum      = {1'b0, div_q} + (DIV_W+1)'(eps_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign last_elem = (7'(i_r + 7'd1) == n_r);

  // Divider operands follow the step that issues the division.
  always_comb begin
    div_start = 1'b0;
    div_a     = DIV_W'(t_r);
    div_b     = DIV_W'(n_r);
    sq_start  = (state_r == ST_SQ_GO);
    unique case (state_r)
      ST_VAR_GO: begin
        div_start = 1'b1;
        div_a     = ssq_r;
        div_b     = DIV_W'(n3_r);
      end
      ST_INV_GO: begin
        div_start = 1'b1;
        div_a     = INV_NUM;
        div_b     = v_r;
      end
      ST_O_GO: begin
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  lnr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  lnr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_src_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (elem_acc && (count_inc >= eff_len)) state_nxt = ST_V_RD;
      ST_V_RD:     state_nxt = ST_V_D;
      ST_V_D:      state_nxt = ST_V_SQ;
      ST_V_SQ:     state_nxt = last_elem ? ST_VAR_GO : ST_V_RD;
      ST_VAR_GO:   state_nxt = ST_VAR_WAIT;
      ST_VAR_WAIT: begin
        if (div_done) state_nxt = (vsum == '0) ? ST_O_RD : ST_INV_GO;
      end
      ST_INV_GO:   state_nxt = ST_INV_WAIT;
      ST_INV_WAIT: if (div_done) state_nxt = ST_SQ_GO;
      ST_SQ_GO:    state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT:  if (sq_done) state_nxt = ST_O_RD;
      ST_O_RD:     state_nxt = ST_O_D;
      ST_O_D:      state_nxt = ST_O_M1;
      ST_O_M1:     state_nxt = ST_O_M2;
      ST_O_M2:     state_nxt = ST_O_GO;
      ST_O_GO:     state_nxt = ST_O_WAIT;
      ST_O_WAIT:   if (div_done) state_nxt = ST_O_OUT;
      ST_O_OUT: begin
        if (out_free) state_nxt = last_elem ? ST_IDLE : ST_O_RD;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Memories: written while idle, read every cycle at the sweep index.
  always_ff @(posedge clk) begin
    if (elem_acc && (count_r < DIM7)) begin
      row_mem[count_r[AW-1:0]] <= in_sample;
    end
    if (load_acc) begin
      par_mem[in_index[AW-1:0]] <= {in_sample, in_shift_value};
    end
    row_rd_r <= row_mem[i_r[AW-1:0]];
    par_rd_r <= par_mem[i_r[AW-1:0]];
    pv_rd_r  <= pvld_r[i_r[AW-1:0]];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r      <= '0;
      rl_r        <= ROW_LEN_RESET;
      eps_r       <= EPS_RESET;
      count_r     <= '0;
      sum_r       <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROW_LENGTH: rl_r  <= cfg_data[6:0];
          CFG_EPS:        eps_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (load_acc) begin
        pvld_r[in_index[AW-1:0]] <= 1'b1;
      end
      if (elem_acc && (count_r < DIM7)) begin
        count_r <= count_inc;
        sum_r   <= sum_r + 22'(in_sample);
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE:     i_r <= '0;
        ST_V_SQ:     i_r <= last_elem ? 7'd0 : 7'(i_r + 7'd1);
        ST_O_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (last_elem) begin
              i_r     <= '0;
              count_r <= '0;
              sum_r   <= '0;
            end else begin
              i_r <= 7'(i_r + 7'd1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        n_r   <= count_inc;
        ssq_r <= '0;
      end
      ST_V_RD: n2_r <= n_r * n_r;
      ST_V_D: begin
        dm_r <= dm;
        n3_r <= n2_r * n_r;
      end
      ST_V_SQ: ssq_r <= ssq_r + DIV_W'(sq);
      ST_VAR_WAIT: begin
        v_r   <= vsum[DIV_W-1:0];
        inv_r <= INV_ZERO;
      end
      ST_INV_WAIT: sq_src_r <= SQ_W'(div_q);
      ST_SQ_WAIT:  if (sq_done) inv_r <= sq_root;
      ST_O_D: begin
        dm_r  <= dm;
        gm_r  <= g_s[15] ? 16'(-g_s) : 16'(g_s);
        sgn_r <= d_s[24] ^ g_s[15];
        shv_r <= signed'(s_raw);
      end
      ST_O_M1:   m1_r <= dm_r * inv_r;
      ST_O_M2:   t_r  <= tsum[63:28];
      ST_O_WAIT: q_r  <= div_q[35:0];
      ST_O_OUT: begin
        if (out_free) begin
          out_pos_r  <= 6'(i_r);
          out_last_r <= last_elem;
          if (y > YMAX) begin
            out_value_r <= 16'sh7FFF;
            out_sat_r   <= 1'b1;
          end else if (y < YMIN) begin
            out_value_r <= -16'sh8000;
            out_sat_r   <= 1'b1;
          end else begin
            out_value_r <= y[15:0];
            out_sat_r   <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_position  = out_pos_r;
  assign out_last      = out_last_r;
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire

/* hw/rtl/lnr_chk.sv */
// ----------------------------------------------------------------------------
// lnr_chk
// Port-level checks for the layer normalization row block.
// ----------------------------------------------------------------------------
`default_nettype none

module lnr_chk (
  input wire               clk,
  input wire               rst_n,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input wire signed [15:0] out_value,
  input wire        [5:0]  out_position,
  input wire               out_last
);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
      $stable(out_position) && $stable(out_last))
    else $error("result changed while stalled");

  // Results are only produced while the input side is held off.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // Reset empties the output register.
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A new result that is not the first of a row follows its predecessor.
  a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last ##1 out_valid |->
      out_position == $past(out_position) + 6'd1)
    else $error("result position out of order");

endmodule

bind layer_norm_row lnr_chk u_lnr_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_value    (out_value),
  .out_position (out_position),
  .out_last     (out_last)
);

`default_nettype wire

/* verif/tb_layer_norm_row.sv */
// ----------------------------------------------------------------------------
// tb_layer_norm_row
// Self-checking bench for the layer normalization row block. A queue-fed
// driver and a clocked monitor surround the block; a bit-accurate model of
// the normalization predicts every result and the monitor checks them in
// order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_layer_norm_row;
  import lnr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_MAX = 64;

  // One input transaction as the driver offers it.
  typedef struct {
    cmd_t              cmd;
    logic [5:0]        index;
    logic signed [15:0] sample;
    logic signed [15:0] shift_value;
  } norm_item_t;

  // One normalized element as the block should return it.
  typedef struct {
    logic signed [15:0] value;
    logic [5:0]         position;
    logic               last;
    logic               saturated;
  } norm_result_t;

  logic clk;
  logic rst_n;

  logic              in_valid;
  logic              in_stall;
  cmd_t              in_cmd;
  logic [5:0]        in_index;
  logic signed [15:0] in_sample;
  logic signed [15:0] in_shift_value;

  logic              out_valid;
  logic              out_stall;
  logic signed [15:0] out_value;
  logic [5:0]        out_position;
  logic              out_last;
  logic              out_saturated;

  logic              cfg_valid;
  logic              cfg_ready;
  cfg_reg_t          cfg_index;
  logic [15:0]       cfg_data;

  layer_norm_row i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_index       (in_index),
    .in_sample      (in_sample),
    .in_shift_value (in_shift_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_position   (out_position),
    .out_last       (out_last),
    .out_saturated  (out_saturated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  norm_item_t   pending_items[$];
  norm_result_t norm_expected[$];

  int  error_count;
  int  results_seen;
  int  rows_done;
  int  items_sent;
  int  send_gap;        // cycles the sender still waits before the next item
  int  recv_gap;        // cycles the receiver still stalls before the next result
  int  hold_left;       // long receiver hold-off, counted down below
  int  hold_request;    // set by the stimulus to start a long hold-off
  bit  send_busy_mode;  // when clear, the sender never idles
  bit  recv_busy_mode;  // when clear, the receiver never stalls

  // Private copy of the block's state.
  logic signed [15:0] scale_mem[ROW_MAX];
  logic signed [15:0] shift_mem[ROW_MAX];
  logic signed [15:0] row_mem[ROW_MAX];
  int                 row_acc;
  int                 row_fill;
  logic [6:0]         len_reg;
  logic [15:0]        eps_reg;

  // --------------------------------------------------------------------------
  // Clock and timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The slowest legal run, including both stalls, is well under this limit.
  initial begin
    #4_000_000;
    $display("layer_norm_row test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Normalizes the buffered row and queues one expected result per element.
  task automatic normalize_row();
    longint          n;
    longint          d;
    longint          y;
    longint unsigned dm;
    longint unsigned gm;
    longint unsigned ssq;
    longint unsigned v;
    longint unsigned inv;
    longint unsigned den;
    longint unsigned q;
    norm_result_t    r;
    n   = row_fill;
    ssq = 0;
    for (int i = 0; i < n; i++) begin
      d   = n * longint'(row_mem[i]) - longint'(row_acc);
      dm  = (d < 0) ? -d : d;
      ssq += dm * dm;
    end
    v   = ssq / (n * n * n) + eps_reg;
    // With zero variance and zero eps the inverse root saturates at 1.0.
    inv = (v == 0) ? (64'd1 << 24) : int_sqrt((64'd1 << 48) / v);
    den = n << 28;
    for (int i = 0; i < n; i++) begin
      d  = n * longint'(row_mem[i]) - longint'(row_acc);
      dm = (d < 0) ? -d : d;
      gm = (scale_mem[i] < 0) ? -longint'(scale_mem[i]) : longint'(scale_mem[i]);
      q  = (dm * inv * gm + den / 2) / den;
      y  = ((d < 0) != (scale_mem[i] < 0)) ? -longint'(q) : longint'(q);
      y  = y + longint'(shift_mem[i]);
      r.saturated = 1'b0;
      if (y > 32767) begin
        y = 32767;
        r.saturated = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        r.saturated = 1'b1;
      end
      r.value    = y[15:0];
      r.position = i[5:0];
      r.last     = (i + 1 == n);
      norm_expected.push_back(r);
    end
    row_fill = 0;
    row_acc  = 0;
  endtask

  task automatic norm_predict(norm_item_t it);
    int eff_len;
    if (it.cmd == CMD_LOAD) begin
      scale_mem[it.index] = it.sample;
      shift_mem[it.index] = it.shift_value;
    end else begin
      if (row_fill < ROW_MAX) begin
        row_mem[row_fill] = it.sample;
        row_acc  += int'(it.sample);
        row_fill++;
      end
      // A length of zero acts as one, anything above the table size as 64.
      eff_len = (len_reg == 0) ? 1 : ((len_reg > ROW_MAX) ? ROW_MAX : len_reg);
      // A length lowered below the current fill closes the row on the next
      // element, over everything buffered so far.
      if (row_fill >= eff_len) begin
        normalize_row();
        rows_done++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offers queued items, with a random gap before each one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        norm_predict('{in_cmd, in_index, in_sample, in_shift_value});
        items_sent++;
      end
      // A stalled transaction keeps its payload; otherwise load the next one.
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          norm_item_t it;
          it = pending_items.pop_front();
          in_valid       <= 1'b1;
          in_cmd         <= it.cmd;
          in_index       <= it.index;
          in_sample      <= it.sample;
          in_shift_value <= it.shift_value;
          send_gap = send_busy_mode ? $urandom_range(0, 11) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off: its own counter, so the sender keeps offering items while
  // the block fills up and stalls its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_request != 0 && hold_left == 0) begin
      hold_left    <= hold_request;
      hold_request = 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: a random number of stall cycles before each result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0 || hold_request != 0) begin
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      // A result taken at this edge starts the wait before the next one.
      if (out_valid && !out_stall) begin
        recv_gap = recv_busy_mode ? $urandom_range(0, 11) : 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every result transaction against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (norm_expected.size() == 0) begin
        $display("%0t: unexpected result value=%0d position=%0d", $time, out_value,
                 out_position);
        error_count++;
      end else begin
        norm_result_t e;
        e = norm_expected.pop_front();
        if (out_value !== e.value) begin
          $display("%0t: out_value expected %0d actual %0d (position %0d)", $time,
                   e.value, out_value, e.position);
          error_count++;
        end
        if (out_position !== e.position) begin
          $display("%0t: position expected %0d actual %0d", $time, e.position,
                   out_position);
          error_count++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last expected %0b actual %0b (position %0d)", $time, e.last,
                   out_last, e.position);
          error_count++;
        end
        if (out_saturated !== e.saturated) begin
          $display("%0t: saturated expected %0b actual %0b (position %0d)", $time,
                   e.saturated, out_saturated, e.position);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic norm_item_t make_load(int idx, int scale, int shift);
    norm_item_t it;
    it.cmd         = CMD_LOAD;
    it.index       = idx[5:0];
    it.sample      = scale[15:0];
    it.shift_value = shift[15:0];
    return it;
  endfunction

  // Element items carry random junk in the fields the block ignores.
  function automatic norm_item_t make_elem(int x);
    norm_item_t it;
    it.cmd         = CMD_ELEM;
    it.index       = 6'($urandom_range(0, 63));
    it.sample      = x[15:0];
    it.shift_value = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  // Mostly moderate samples so the output is not always clipped, with some
  // full-range ones.
  function automatic int rand_sample();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 65535) - 32768;
      1:       return $urandom_range(0, 255) - 128;
      default: return $urandom_range(0, 4095) - 2048;
    endcase
  endfunction

  function automatic norm_item_t rand_load();
    if ($urandom_range(0, 2) == 0) begin
      return make_load($urandom_range(0, 63), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
    end
    return make_load($urandom_range(0, 63), $urandom_range(0, 8191) - 4096,
                     $urandom_range(0, 2047) - 1024);
  endfunction

  // Waits until every queued item is taken and every result has come back,
  // then lets the sequencer settle before the configuration changes.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || norm_expected.size() != 0);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROW_LENGTH) len_reg = data[6:0];
    else eps_reg = data;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int lens[8];
    int epss[8];

    error_count    = 0;
    results_seen   = 0;
    rows_done      = 0;
    items_sent     = 0;
    send_gap       = 0;
    recv_gap       = 0;
    hold_request   = 0;
    send_busy_mode = 1'b1;
    recv_busy_mode = 1'b1;
    for (int i = 0; i < ROW_MAX; i++) begin
      scale_mem[i] = SCALE_ONE;
      shift_mem[i] = SHIFT_ZERO;
      row_mem[i]   = '0;
    end
    row_acc  = 0;
    row_fill = 0;
    len_reg  = ROW_LEN_RESET;
    eps_reg  = EPS_RESET;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_LOAD;
    in_index       = '0;
    in_sample      = '0;
    in_shift_value = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_ROW_LENGTH;
    cfg_data       = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Short rows, zero eps, and the table extremes.
    write_cfg(CFG_ROW_LENGTH, 16'd4);
    write_cfg(CFG_EPS, 16'd0);
    pending_items.push_back(make_load(0, 32767, 32767));
    pending_items.push_back(make_load(1, -32768, -32768));
    pending_items.push_back(make_load(63, 0, 0));
    // Largest swing in both directions drives the output into clipping.
    pending_items.push_back(make_elem(-32768));
    pending_items.push_back(make_elem(32767));
    pending_items.push_back(make_elem(-32768));
    pending_items.push_back(make_elem(32767));
    // A flat row with zero eps: zero variance, inverse root at its ceiling.
    for (int i = 0; i < 4; i++) pending_items.push_back(make_elem(5));
    wait_idle();

    // Row length zero behaves as one.
    write_cfg(CFG_ROW_LENGTH, 16'd0);
    pending_items.push_back(make_elem(-300));
    pending_items.push_back(make_elem(32767));
    wait_idle();

    // Start a 16-element row, then shorten the row mid-way: the next element
    // closes a row of seven over everything buffered.
    write_cfg(CFG_ROW_LENGTH, 16'd16);
    for (int i = 0; i < 6; i++) pending_items.push_back(make_elem(rand_sample()));
    wait_idle();
    write_cfg(CFG_ROW_LENGTH, 16'd3);
    pending_items.push_back(make_elem(rand_sample()));
    wait_idle();

    // Random part: several settings, the extremes among them. Full rows are
    // slow, so most phases use short rows.
    lens = '{127, 1, 2, 5, 8, 3, 64, 13};
    epss = '{65535, 0, 1, 300, 7, 65535, 0, 40};
    for (int p = 0; p < 8; p++) begin
      int n_items;
      write_cfg(CFG_ROW_LENGTH, lens[p][15:0]);
      write_cfg(CFG_EPS, epss[p][15:0]);
      send_busy_mode = (p % 3 != 1);
      recv_busy_mode = (p % 3 != 2);
      // Hold the receiver off for a long stretch while rows keep coming.
      if (p == 4) hold_request = 900;
      n_items = (lens[p] >= 64) ? 64 : 40;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 4) == 0) pending_items.push_back(rand_load());
        else pending_items.push_back(make_elem(rand_sample()));
      end
      // Finish the row so the next setting starts from an empty buffer.
      while (pending_items.size() != 0 || in_valid) @(posedge clk);
      if (row_fill != 0) begin
        int missing;
        missing = ((lens[p] > ROW_MAX) ? ROW_MAX : lens[p]) - row_fill;
        for (int k = 0; k < missing; k++) pending_items.push_back(make_elem(rand_sample()));
      end
      wait_idle();
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d input transactions, %0d rows and %0d checked results.",
             items_sent, rows_done, results_seen);
    $display("Row lengths from 1 to 64 with eps from 0 to 65535 under random stalls.");
    if (error_count == 0) begin
      $display("layer_norm_row test passed");
    end else begin
      $display("layer_norm_row test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
